### hdl/wtsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtsp_pkg: shared types, constants and helpers of the weekday time parser
// Holds the parser state layout, the day name table and the character tests
// ----------------------------------------------------------------------------
package wtsp_pkg;

	localparam int MAX_LEN     = 255;
	localparam int POS_LIMIT   = (MAX_LEN < 255) ? MAX_LEN : 255;
	localparam int NAME_COUNT  = 21;
	localparam int NAME_CHARS  = 9;
	localparam int NAME_LEN_MAX = 15;

	localparam logic [6:0]  ACC_MAX      = 7'd127;
	localparam logic [6:0]  HOUR_MAX     = 7'd23;
	localparam logic [6:0]  SUB_MAX      = 7'd59;
	localparam logic [15:0] INVALID_VALUE = 16'hFFFF;

	localparam int DAY_TICKS  = 24 * 60 * 6;
	localparam int HOUR_TICKS = 60 * 6;
	localparam int MIN_TICKS  = 6;
	// second / 10 as (second * 205) >> 11, exact for all 7-bit values
	localparam int SEC_RECIP  = 205;
	localparam int SEC_SHIFT  = 11;

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_COLON = 8'd58;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_SIX   = 8'd54;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_D     = 8'd100;
	localparam logic [7:0] CH_UA    = 8'd65;
	localparam logic [7:0] CH_UZ    = 8'd90;
	localparam logic [7:0] CH_LA    = 8'd97;
	localparam logic [7:0] CH_LZ    = 8'd122;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CASE_GAP = 8'd32;

	localparam logic [NAME_COUNT-1:0] MASK_ALL = '1;

	// names are left aligned, padded with spaces; bytes past the length are never compared
	localparam logic [8*NAME_CHARS-1:0] DAY_WORD [NAME_COUNT] = '{
		"mo       ", "mon      ", "monday   ",
		"tu       ", "tue      ", "tuesday  ",
		"we       ", "wed      ", "wednesday",
		"th       ", "thu      ", "thursday ",
		"fr       ", "fri      ", "friday   ",
		"sa       ", "sat      ", "saturday ",
		"su       ", "sun      ", "sunday   "
	};
	localparam logic [3:0] DAY_LEN [NAME_COUNT] = '{
		4'd2, 4'd3, 4'd6, 4'd2, 4'd3, 4'd7, 4'd2, 4'd3, 4'd9, 4'd2, 4'd3,
		4'd8, 4'd2, 4'd3, 4'd6, 4'd2, 4'd3, 4'd8, 4'd2, 4'd3, 4'd6
	};
	localparam logic [2:0] DAY_NUM [NAME_COUNT] = '{
		3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3,
		3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd6, 3'd6, 3'd6
	};

	typedef enum logic [3:0] {
		PH_START,
		PH_WDIGIT,
		PH_NAME,
		PH_NAME_WS,
		PH_HOUR_FIRST,
		PH_HOUR,
		PH_MIN,
		PH_SEC,
		PH_DONE
	} phase_t;

	typedef struct packed {
		phase_t                phase;
		logic [2:0]            weekday;
		logic [6:0]            hour;
		logic [6:0]            minute;
		logic [6:0]            second;
		logic [1:0]            digits;
		logic [NAME_COUNT-1:0] mask;
		logic [3:0]            name_len;
		logic [7:0]            position;
		logic [7:0]            consumed;
		logic                  error;
	} parse_state_t;

	// what the result stage needs from a finished string
	typedef struct packed {
		logic [2:0] weekday;
		logic [6:0] hour;
		logic [6:0] minute;
		logic [6:0] second;
		logic [7:0] consumed;
		logic       error;
	} parse_final_t;

	localparam parse_state_t PARSE_RESET = '{
		phase:    PH_START,
		weekday:  3'd0,
		hour:     7'd0,
		minute:   7'd0,
		second:   7'd0,
		digits:   2'd0,
		mask:     MASK_ALL,
		name_len: 4'd0,
		position: 8'd0,
		consumed: 8'd0,
		error:    1'b0
	};

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return c inside {[CH_ZERO:CH_NINE]};
	endfunction

	function automatic logic [6:0] acc_push(input logic [6:0] acc, input logic [7:0] c);
		logic [10:0] v;
		v = 11'(acc) * 11'd10 + 11'(c - CH_ZERO);
		return (v > 11'(ACC_MAX)) ? ACC_MAX : v[6:0];
	endfunction

	function automatic logic [7:0] day_char(input int i, input logic [3:0] idx);
		logic [8*NAME_CHARS-1:0] word;
		logic [7:0]              r;
		word = DAY_WORD[i];
		r    = CH_NUL;
		for (int k = 0; k < NAME_CHARS; k++) begin
			if (idx == 4'(k)) begin
				r = word[8*(NAME_CHARS-1-k) +: 8];
			end
		end
		return r;
	endfunction

	// keep the candidates whose character at idx equals c, ignoring case
	function automatic logic [NAME_COUNT-1:0] mask_step(input logic [NAME_COUNT-1:0] m,
			input logic [3:0] idx, input logic [7:0] c);
		logic [7:0]            lc;
		logic [NAME_COUNT-1:0] keep;
		lc   = (c inside {[CH_UA:CH_UZ]}) ? c + CASE_GAP : c;
		keep = '0;
		for (int i = 0; i < NAME_COUNT; i++) begin
			keep[i] = (idx < DAY_LEN[i]) && (day_char(i, idx) == lc);
		end
		return m & keep;
	endfunction

	function automatic logic field_ok(input logic [1:0] digits, input logic [6:0] acc);
		return (digits >= 2'd2) && (acc <= SUB_MAX);
	endfunction

	function automatic parse_state_t st_fail(input parse_state_t s);
		parse_state_t r;
		r       = s;
		r.error = 1'b1;
		r.phase = PH_DONE;
		return r;
	endfunction

	function automatic parse_state_t st_accept(input parse_state_t s, input logic [7:0] cnt);
		parse_state_t r;
		r          = s;
		r.consumed = cnt;
		r.error    = 1'b0;
		r.phase    = PH_DONE;
		return r;
	endfunction

	// end of string reached while still parsing
	function automatic parse_state_t st_finish(input parse_state_t s);
		parse_state_t r;
		if (s.phase == PH_MIN && field_ok(s.digits, s.minute)) begin
			r = st_accept(s, s.position);
		end else if (s.phase == PH_SEC && field_ok(s.digits, s.second)) begin
			r = st_accept(s, s.position);
		end else begin
			r = st_fail(s);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hdl/wtsp_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtsp_step: one character of parser next-state logic
// Advances the parse state by one character and closes the parse on the
// final character of a string
// ----------------------------------------------------------------------------
module wtsp_step
	import wtsp_pkg::*;
(
	input  wire parse_state_t st,
	input  wire logic [7:0]   ch,
	input  wire logic         last,
	output parse_state_t      nxt
);

	parse_state_t      cons;
	parse_state_t      mid;
	logic [7:0]        pos_inc;
	logic              name_hit;
	logic [2:0]        name_day;
	logic [7:0]        dval;

	assign pos_inc = st.position + 8'd1;
	assign dval    = ch - CH_ZERO;

	// a finished name token: the candidate whose length equals the token length
	always_comb begin
		name_hit = 1'b0;
		name_day = 3'd0;
		for (int i = 0; i < NAME_COUNT; i++) begin
			if (st.mask[i] && DAY_LEN[i] == st.name_len) begin
				name_hit = 1'b1;
				name_day = DAY_NUM[i];
			end
		end
	end

	always_comb begin
		cons          = st;
		cons.position = pos_inc;
		case (st.phase)
			PH_START: begin
				if (is_ws(ch)) begin
					cons.phase = PH_START;
				end else if (ch inside {[CH_ZERO:CH_SIX]}) begin
					cons.weekday = dval[2:0];
					cons.hour    = dval[6:0];
					cons.phase   = PH_WDIGIT;
				end else if (is_dig(ch)) begin
					cons.hour  = dval[6:0];
					cons.phase = PH_HOUR;
				end else if ((ch inside {[CH_LA:CH_LZ]}) || (ch inside {[CH_UA:CH_UZ]})) begin
					cons.mask     = mask_step(MASK_ALL, 4'd0, ch);
					cons.name_len = 4'd1;
					cons.phase    = PH_NAME;
				end else begin
					cons = st_fail(cons);
				end
			end
			PH_WDIGIT: begin
				if (ch == CH_D) begin
					cons.hour  = 7'd0;
					cons.phase = PH_HOUR_FIRST;
				end else begin
					// the digit was the first hour digit after all
					cons.weekday = 3'd0;
					cons.phase   = PH_HOUR;
					if (is_dig(ch)) begin
						cons.hour = acc_push(st.hour, ch);
					end else if (ch == CH_COLON) begin
						cons.digits = 2'd0;
						cons.phase  = PH_MIN;
					end else begin
						cons = st_fail(cons);
					end
				end
			end
			PH_NAME: begin
				if (is_ws(ch)) begin
					if (name_hit) begin
						cons.weekday = name_day;
						cons.phase   = PH_NAME_WS;
					end else begin
						cons = st_fail(cons);
					end
				end else begin
					cons.mask = mask_step(st.mask, st.name_len, ch);
					if (st.name_len < 4'(NAME_LEN_MAX)) begin
						cons.name_len = st.name_len + 4'd1;
					end
				end
			end
			PH_NAME_WS, PH_HOUR_FIRST: begin
				if (st.phase == PH_NAME_WS && is_ws(ch)) begin
					cons.phase = PH_NAME_WS;
				end else if (is_dig(ch)) begin
					cons.hour  = dval[6:0];
					cons.phase = PH_HOUR;
				end else begin
					cons = st_fail(cons);
				end
			end
			PH_HOUR: begin
				if (is_dig(ch)) begin
					cons.hour = acc_push(st.hour, ch);
				end else if (ch == CH_COLON && st.hour <= HOUR_MAX) begin
					cons.digits = 2'd0;
					cons.phase  = PH_MIN;
				end else begin
					cons = st_fail(cons);
				end
			end
			PH_MIN: begin
				if (is_dig(ch)) begin
					cons.minute = acc_push(st.minute, ch);
					if (st.digits != 2'd3) begin
						cons.digits = st.digits + 2'd1;
					end
				end else if (!field_ok(st.digits, st.minute)) begin
					cons = st_fail(cons);
				end else if (ch == CH_COLON) begin
					cons.digits = 2'd0;
					cons.phase  = PH_SEC;
				end else if (is_ws(ch)) begin
					cons = st_accept(cons, pos_inc);
				end else begin
					cons = st_fail(cons);
				end
			end
			PH_SEC: begin
				if (is_dig(ch)) begin
					cons.second = acc_push(st.second, ch);
					if (st.digits != 2'd3) begin
						cons.digits = st.digits + 2'd1;
					end
				end else if (is_ws(ch) && field_ok(st.digits, st.second)) begin
					cons = st_accept(cons, pos_inc);
				end else begin
					cons = st_fail(cons);
				end
			end
			default: begin
				cons = st;
			end
		endcase
	end

	always_comb begin
		if (st.phase == PH_DONE) begin
			mid = st;
		end else if (ch == CH_NUL) begin
			// a zero byte ends the string and is not counted
			mid = st_finish(st);
		end else if (st.position >= 8'(POS_LIMIT)) begin
			mid = st_fail(st);
		end else begin
			mid = cons;
		end
		if (last && mid.phase != PH_DONE) begin
			nxt = st_finish(mid);
		end else begin
			nxt = mid;
		end
	end

endmodule
`default_nettype wire

### hdl/wtsp_value.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wtsp_value: result formatting for a finished string
// Turns weekday, hour, minute and second into ten-second intervals since
// Monday 0:00, or the invalid code
// ----------------------------------------------------------------------------
module wtsp_value
	import wtsp_pkg::*;
(
	input  wire parse_final_t fin,
	output logic [15:0]       time_value,
	output logic              valid_res,
	output logic [7:0]        consumed
);

	logic [17:0] sec_prod;
	logic [15:0] tens;
	logic [15:0] sum;

	assign sec_prod = 18'(fin.second) * 18'(SEC_RECIP);
	assign tens     = 16'(sec_prod >> SEC_SHIFT);
	assign sum      = 16'(fin.weekday) * 16'(DAY_TICKS)
	                + 16'(fin.hour) * 16'(HOUR_TICKS)
	                + 16'(fin.minute) * 16'(MIN_TICKS)
	                + tens;

	always_comb begin
		if (fin.error) begin
			time_value = INVALID_VALUE;
			valid_res  = 1'b0;
			consumed   = 8'd0;
		end else begin
			time_value = sum;
			valid_res  = 1'b1;
			consumed   = fin.consumed;
		end
	end

endmodule
`default_nettype wire

### hdl/weekday_time_string_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// weekday_time_string_parser: streaming parser for weekday time strings
// Reads "[weekday] hh:mm[:ss]" one character per transaction and reports
// ten-second intervals since Monday 0:00 on the string's final character
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle with no gaps needed between
// characters or between strings. Each character is registered, then applied to
// the parse state; day names are matched against all 21 names in parallel.
// The final character of a string (last = 1) produces one result transaction:
// its closed parse is registered in the final stage, then the interval count is
// formed in the output register. A result waiting under out_stall does not
// hold up input; input stalls only when a later final character finds the
// result path still full.
module weekday_time_string_parser
	import wtsp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  ch,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      time_value,
	output logic             valid_res,
	output logic [7:0]       consumed
);

	logic         valid_s1;
	logic [7:0]   ch_s1;
	logic         last_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         valid_s2;
	parse_final_t fin_s2;
	logic         out_valid_q;
	logic [15:0]  time_value_q;
	logic         valid_res_q;
	logic [7:0]   consumed_q;
	logic [15:0]  time_value_d;
	logic         valid_res_d;
	logic [7:0]   consumed_d;
	logic         out_free;
	logic         s2_free;
	logic         s1_go;
	logic         s1_free;

	// a stage moves when the stage after it is empty or moving; only a final character waits in stage 1
	assign out_free = !out_valid_q || !out_stall;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_go    = valid_s1 && (!last_s1 || s2_free);
	assign s1_free  = !valid_s1 || s1_go;
	assign in_stall = !s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	wtsp_step u_step (
		.st   (state_q),
		.ch   (ch_s1),
		.last (last_s1),
		.nxt  (state_nxt)
	);

	// parse state returns to reset after each string's final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PARSE_RESET;
		end else if (s1_go) begin
			state_q <= last_s1 ? PARSE_RESET : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_go && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_go && last_s1) begin
			fin_s2.weekday  <= state_nxt.weekday;
			fin_s2.hour     <= state_nxt.hour;
			fin_s2.minute   <= state_nxt.minute;
			fin_s2.second   <= state_nxt.second;
			fin_s2.consumed <= state_nxt.consumed;
			fin_s2.error    <= state_nxt.error;
		end
	end

	wtsp_value u_value (
		.fin        (fin_s2),
		.time_value (time_value_d),
		.valid_res  (valid_res_d),
		.consumed   (consumed_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			time_value_q <= time_value_d;
			valid_res_q  <= valid_res_d;
			consumed_q   <= consumed_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign time_value = time_value_q;
	assign valid_res  = valid_res_q;
	assign consumed   = consumed_q;

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for weekday_time_string_parser
// Streams directed and random time strings through the parser with random
// input gaps and output stalls, predicts every result with a cycle-free
// model of the parse and compares each result transaction field by field
// ----------------------------------------------------------------------------
module tb_top;
	import wtsp_pkg::*;

	localparam int LEN_LIMIT   = 255;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] c;
		logic       fin;
	} char_item_t;

	typedef struct {
		logic [15:0] tv;
		logic        ok;
		logic [7:0]  cnt;
	} parse_result_t;

	class time_string_checker;
		string         day_names[21];
		parse_result_t expected_times[$];
		int            mismatch_count;
		phase_t        ph;
		logic [2:0]    wday;
		logic [6:0]    hr, mn, sc;
		logic [1:0]    ndig;
		logic [20:0]   cand;
		logic [3:0]    nlen;
		logic [7:0]    pos, used;
		logic          bad;

		function new();
			day_names = '{"mo", "mon", "monday", "tu", "tue", "tuesday", "we", "wed",
				"wednesday", "th", "thu", "thursday", "fr", "fri", "friday", "sa", "sat",
				"saturday", "su", "sun", "sunday"};
			mismatch_count = 0;
			clear();
		endfunction

		function void clear();
			ph   = PH_START;
			wday = '0;
			hr   = '0;
			mn   = '0;
			sc   = '0;
			ndig = '0;
			cand = '1;
			nlen = '0;
			pos  = '0;
			used = '0;
			bad  = 1'b0;
		endfunction

		function logic is_space(logic [7:0] c);
			return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
		endfunction

		function logic is_digit(logic [7:0] c);
			return c >= CH_ZERO && c <= CH_NINE;
		endfunction

		function logic [6:0] push_digit(logic [6:0] acc, logic [7:0] c);
			int v;
			v = int'(acc) * 10 + int'(c) - int'(CH_ZERO);
			return (v > 127) ? 7'd127 : 7'(v);
		endfunction

		function logic sub_ok(logic [6:0] acc);
			return ndig >= 2'd2 && acc <= 7'd59;
		endfunction

		function void set_fail();
			bad = 1'b1;
			ph  = PH_DONE;
		endfunction

		function void set_done();
			used = pos;
			bad  = 1'b0;
			ph   = PH_DONE;
		endfunction

		// end of string while the parse is still open
		function void close_string();
			if (ph == PH_MIN && sub_ok(mn)) begin
				set_done();
			end else if (ph == PH_SEC && sub_ok(sc)) begin
				set_done();
			end else begin
				set_fail();
			end
		endfunction

		// drop the day names whose character at idx differs, ignoring case
		function logic [20:0] narrow(logic [20:0] m, int idx, logic [7:0] c);
			logic [7:0]  lc;
			logic [20:0] keep;
			lc   = (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
			keep = '0;
			for (int i = 0; i < 21; i++) begin
				if (idx < day_names[i].len() && 8'(day_names[i][idx]) == lc) begin
					keep[i] = 1'b1;
				end
			end
			return m & keep;
		endfunction

		function void advance(logic [7:0] c);
			int hit;
			hit = -1;
			case (ph)
				PH_START: begin
					if (!is_space(c)) begin
						if (c >= CH_ZERO && c <= CH_SIX) begin
							wday = 3'(c - CH_ZERO);
							hr   = 7'(c - CH_ZERO);
							ph   = PH_WDIGIT;
						end else if (is_digit(c)) begin
							hr = 7'(c - CH_ZERO);
							ph = PH_HOUR;
						end else if ((c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ)) begin
							cand = narrow('1, 0, c);
							nlen = 4'd1;
							ph   = PH_NAME;
						end else begin
							set_fail();
						end
					end
				end
				PH_WDIGIT: begin
					if (c == CH_D) begin
						hr = '0;
						ph = PH_HOUR_FIRST;
					end else begin
						// the digit was the first hour digit after all
						wday = '0;
						ph   = PH_HOUR;
						if (is_digit(c)) begin
							hr = push_digit(hr, c);
						end else if (c == CH_COLON) begin
							ndig = '0;
							ph   = PH_MIN;
						end else begin
							set_fail();
						end
					end
				end
				PH_NAME: begin
					if (is_space(c)) begin
						for (int i = 0; i < 21; i++) begin
							if (hit < 0 && cand[i] && day_names[i].len() == int'(nlen)) begin
								hit = i;
							end
						end
						if (hit < 0) begin
							set_fail();
						end else begin
							wday = 3'(hit / 3);
							ph   = PH_NAME_WS;
						end
					end else begin
						cand = narrow(cand, int'(nlen), c);
						if (nlen < 4'd15) begin
							nlen++;
						end
					end
				end
				PH_NAME_WS, PH_HOUR_FIRST: begin
					if (!(ph == PH_NAME_WS && is_space(c))) begin
						if (is_digit(c)) begin
							hr = 7'(c - CH_ZERO);
							ph = PH_HOUR;
						end else begin
							set_fail();
						end
					end
				end
				PH_HOUR: begin
					if (is_digit(c)) begin
						hr = push_digit(hr, c);
					end else if (c == CH_COLON && hr <= 7'd23) begin
						ndig = '0;
						ph   = PH_MIN;
					end else begin
						set_fail();
					end
				end
				PH_MIN: begin
					if (is_digit(c)) begin
						mn = push_digit(mn, c);
						if (ndig < 2'd3) begin
							ndig++;
						end
					end else if (!sub_ok(mn)) begin
						set_fail();
					end else if (c == CH_COLON) begin
						ndig = '0;
						ph   = PH_SEC;
					end else if (is_space(c)) begin
						set_done();
					end else begin
						set_fail();
					end
				end
				PH_SEC: begin
					if (is_digit(c)) begin
						sc = push_digit(sc, c);
						if (ndig < 2'd3) begin
							ndig++;
						end
					end else if (is_space(c) && sub_ok(sc)) begin
						set_done();
					end else begin
						set_fail();
					end
				end
				default: begin
				end
			endcase
		endfunction

		// accepted input transaction
		function void take_char(logic [7:0] c, logic fin);
			parse_result_t r;
			int            v;
			if (ph != PH_DONE) begin
				if (c == CH_NUL) begin
					close_string();
				end else if (int'(pos) >= LEN_LIMIT) begin
					set_fail();
				end else begin
					pos++;
					advance(c);
				end
			end
			if (fin) begin
				if (ph != PH_DONE) begin
					close_string();
				end
				if (bad) begin
					r.tv  = INVALID_VALUE;
					r.ok  = 1'b0;
					r.cnt = '0;
				end else begin
					v = int'(wday) * DAY_TICKS + int'(hr) * HOUR_TICKS + int'(mn) * MIN_TICKS
						+ int'(sc) / 10;
					r.tv  = 16'(v);
					r.ok  = 1'b1;
					r.cnt = used;
				end
				expected_times.push_back(r);
				clear();
			end
		endfunction

		// accepted result transaction
		function void check_result(logic [15:0] tv, logic ok, logic [7:0] cnt);
			parse_result_t e;
			if (expected_times.size() == 0) begin
				$display("%0t: unexpected result, time_value %0d valid_res %0b consumed %0d",
					$time, tv, ok, cnt);
				mismatch_count++;
				return;
			end
			e = expected_times.pop_front();
			if (tv !== e.tv) begin
				$display("%0t: time_value expected %0d actual %0d", $time, e.tv, tv);
				mismatch_count++;
			end
			if (ok !== e.ok) begin
				$display("%0t: valid_res expected %0b actual %0b", $time, e.ok, ok);
				mismatch_count++;
			end
			if (cnt !== e.cnt) begin
				$display("%0t: consumed expected %0d actual %0d", $time, e.cnt, cnt);
				mismatch_count++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  ch = '0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] time_value;
	logic        valid_res;
	logic [7:0]  consumed;

	time_string_checker time_sb;
	char_item_t         stim_q[$];
	logic [7:0]         line_q[$];
	int                 cycle_count = 0;
	int                 stall_mode = 0;
	int                 stall_left = 0;

	weekday_time_string_parser u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.ch         (ch),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.time_value (time_value),
		.valid_res  (valid_res),
		.consumed   (consumed)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver stall pattern in one of four randomly chosen styles
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 160);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= 1'($urandom_range(0, 1));
			end
			2: begin
				out_stall <= (stall_left % 4) != 0;
			end
			default: begin
				out_stall <= $urandom_range(0, 7) == 0;
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			time_sb.take_char(ch, last);
		end
		if (arst_n && out_valid && !out_stall) begin
			time_sb.check_result(time_value, valid_res, consumed);
		end
	end

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			line_q.push_back(8'(s[i]));
		end
	endfunction

	function automatic void commit_line();
		foreach (line_q[i]) begin
			stim_q.push_back('{c: line_q[i], fin: (i == line_q.size() - 1)});
		end
		line_q.delete();
	endfunction

	function automatic void line(string s);
		put_text(s);
		commit_line();
	endfunction

	function automatic logic [7:0] pick_space();
		int r;
		r = $urandom_range(8, 13);
		return (r == 8) ? CH_SPACE : 8'(r);
	endfunction

	// mostly two digits, sometimes one or three
	function automatic void put_number(int v, logic vary);
		int r;
		r = vary ? $urandom_range(0, 9) : 5;
		if (r == 0) begin
			put_text($sformatf("%0d", v));
		end else if (r == 1) begin
			put_text($sformatf("%03d", v));
		end else begin
			put_text($sformatf("%02d", v));
		end
	endfunction

	function automatic void build_directed();
		line("0:00");
		line("6d23:59:59");
		line("  Sunday  12:30 ");
		line("MON\t1:05:07");
		line("5:07");
		line("7d1:00");
		line("24:00");
		line("12:5");
		line("12:0059 x");
		line("12:60");
		line("999:00");
		line("wEdNeSdAy 1:00x");
		put_text("1:00");
		line_q.push_back(CH_NUL);
		line("zz");
		line("xyz 1:00");
		line("tu 23:59:5");
		line("thursday 9:15:60");
		line("3d 1:00");
		line("0d0:00:127");
		line("mondaymondaymonday 1:00");
		line_q.push_back(8'd11);
		line_q.push_back(8'd12);
		line_q.push_back(CH_CR);
		line("\n fri 0:01 ");
		line("7");
		line_q.push_back(CH_NUL);
		commit_line();
		line_q.push_back(8'hFF);
		commit_line();
		// longest string that still fits, then one character over
		repeat (251) line_q.push_back(CH_SPACE);
		line("1:00");
		repeat (252) line_q.push_back(CH_SPACE);
		line("1:00");
		line("su\t\t7:07:07 trailing");
	endfunction

	function automatic int random_line();
		int         idx, v, cut, n;
		logic [7:0] b;
		string      nm;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 10)) line_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 1)) begin
				repeat ($urandom_range(1, 3)) line_q.push_back(pick_space());
			end
			case ($urandom_range(0, 2))
				1: begin
					put_text($sformatf("%0dd", $urandom_range(0, 7)));
				end
				2: begin
					idx = $urandom_range(0, 20);
					nm  = time_sb.day_names[idx];
					for (int i = 0; i < nm.len(); i++) begin
						b = 8'(nm[i]);
						line_q.push_back($urandom_range(0, 1) ? b - 8'd32 : b);
					end
					if ($urandom_range(0, 9) == 0) begin
						line_q[line_q.size() - 1] = 8'($urandom_range(97, 122));
					end
					repeat ($urandom_range(1, 3)) line_q.push_back(pick_space());
				end
				default: begin
				end
			endcase
			v = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 140) : $urandom_range(0, 23);
			if ($urandom_range(0, 1)) begin
				put_text($sformatf("%0d", v));
			end else begin
				put_text($sformatf("%02d", v));
			end
			line_q.push_back(CH_COLON);
			put_number(($urandom_range(0, 9) == 0) ? $urandom_range(60, 99)
				: $urandom_range(0, 59), 1'b1);
			if ($urandom_range(0, 1)) begin
				line_q.push_back(CH_COLON);
				put_number(($urandom_range(0, 9) == 0) ? $urandom_range(60, 140)
					: $urandom_range(0, 59), 1'b1);
			end
			case ($urandom_range(0, 5))
				1, 5: begin
					line_q.push_back(pick_space());
				end
				2: begin
					line_q.push_back(pick_space());
					put_text("x9:");
				end
				3: begin
					line_q.push_back(CH_NUL);
					put_text("9");
				end
				4: begin
					line_q.push_back(8'($urandom_range(0, 255)));
				end
				default: begin
				end
			endcase
			if ($urandom_range(0, 9) == 0) begin
				line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
			end
			if ($urandom_range(0, 14) == 0) begin
				cut    = $urandom_range(1, line_q.size());
				line_q = line_q[0:cut-1];
			end
		end
		n = line_q.size();
		commit_line();
		return n;
	endfunction

	// sender: bursts of random length, random gaps, some long bursts with no gap
	task automatic drive_chars();
		int idx, burst, gap, k;
		idx = 0;
		while (idx < stim_q.size()) begin
			burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
			gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			k     = 0;
			while (k < burst && idx < stim_q.size()) begin
				in_valid <= 1'b1;
				ch       <= stim_q[idx].c;
				last     <= stim_q[idx].fin;
				do @(posedge clk); while (in_stall);
				idx++;
				k++;
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		int random_chars, random_lines;
		time_sb      = new();
		random_chars = 0;
		random_lines = 0;
		build_directed();
		// directed strings already carry most of the item budget
		while (random_chars < 80 || random_lines < 8) begin
			random_chars += random_line();
			random_lines++;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		drive_chars();
		do @(posedge clk); while (time_sb.expected_times.size() != 0);
		repeat (8) @(posedge clk);
		if (time_sb.mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
